// ----- rtl/pltc_pkg.sv -----
// Shared types, constants and helpers for the piecewise-linear tone curve unit.
// Depends on nothing; every other file in rtl/ imports this package.
package pltc_pkg;

    localparam int PLTC_MAX_POINTS = 16;
    localparam int LEVEL_W         = 8;
    localparam int SLOT_W          = 4;
    localparam int PROD_W          = 2 * LEVEL_W;
    localparam int DIV_STAGES      = 4;
    localparam int DIV_BITS        = LEVEL_W / DIV_STAGES;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [PROD_W-1:0]  prod_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_kind_t;

    // Request payload: one breakpoint load or one pixel
    typedef struct packed {
        req_kind_t          req_type;
        logic [SLOT_W-1:0]  point_slot;
        level_t             point_in_level;
        level_t             point_out_level;
        level_t             pixel_value;
    } pltc_req_t;

    // Result payload
    typedef struct packed {
        level_t mapped_value;
        logic   past_last_point;
    } pltc_res_t;

    // Segment found by the lookup stage
    typedef struct packed {
        logic   direct;
        level_t direct_value;
        logic   past_last;
        level_t px;
        level_t x0;
        level_t x1;
        level_t y0;
        level_t y1;
    } pltc_seg_t;

    // Weighted terms after the multipliers
    typedef struct packed {
        logic   direct;
        level_t direct_value;
        logic   past_last;
        prod_t  p0;
        prod_t  p1;
        level_t den;
    } pltc_prod_t;

    // Numerator and divisor ready for division
    typedef struct packed {
        logic   direct;
        level_t direct_value;
        logic   past_last;
        prod_t  num;
        level_t den;
    } pltc_frac_t;

    // Partial division state carried between divider stages
    typedef struct packed {
        logic   direct;
        level_t direct_value;
        logic   past_last;
        level_t rem;
        level_t quo;
        level_t num_lo;
        level_t den;
    } pltc_div_t;

endpackage

// ----- rtl/pltc_lookup.sv -----
// Breakpoint table and segment search: compare the pixel against every knot,
// pick the first knot at or above it and its predecessor. Imports pltc_pkg.
module pltc_lookup
    import pltc_pkg::*;
#(
    parameter int MAX_POINTS = PLTC_MAX_POINTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  pltc_req_t req,
    output logic      seg_valid,
    input  logic      seg_ready,
    output pltc_seg_t seg
);

    level_t    knot_in_reg  [MAX_POINTS];
    level_t    knot_out_reg [MAX_POINTS];
    logic      seg_valid_reg;
    logic      seg_valid_next;
    pltc_seg_t seg_reg;
    pltc_seg_t seg_next;

    logic                  stage_ready;
    logic                  req_take;
    logic                  load_we;
    logic                  pixel_take;
    logic [MAX_POINTS-1:0] ge;
    logic [MAX_POINTS-1:0] first;

    assign stage_ready = ~seg_valid_reg | seg_ready;
    assign req_stall   = ~stage_ready;
    assign req_take    = req_valid & stage_ready;
    assign load_we     = req_take & (req.req_type == REQ_LOAD);
    assign pixel_take  = req_take & (req.req_type == REQ_PIXEL);

    // Write one breakpoint; slots past the table never match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                knot_in_reg[i]  <= '1;
                knot_out_reg[i] <= '1;
            end
        end
        else if (load_we)
        begin
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (32'(req.point_slot) == i)
                begin
                    knot_in_reg[i]  <= req.point_in_level;
                    knot_out_reg[i] <= req.point_out_level;
                end
            end
        end
    end

    // Compare all knots, keep the first hit, select hit and predecessor
    always_comb
    begin
        logic   seen;
        logic   hit;
        level_t x0;
        level_t x1;
        level_t y0;
        level_t y1;
        seen = 1'b0;
        x0   = '0;
        x1   = '0;
        y0   = '0;
        y1   = '0;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            ge[i]    = (knot_in_reg[i] >= req.pixel_value);
            first[i] = ge[i] & ~seen;
            seen     = seen | ge[i];
        end
        hit = seen;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (first[i])
            begin
                x1 = x1 | knot_in_reg[i];
                y1 = y1 | knot_out_reg[i];
            end
        end
        for (int i = 0; i < MAX_POINTS - 1; i++)
        begin
            if (first[i+1])
            begin
                x0 = x0 | knot_in_reg[i];
                y0 = y0 | knot_out_reg[i];
            end
        end
        seg_next.px           = req.pixel_value;
        seg_next.x0           = x0;
        seg_next.x1           = x1;
        seg_next.y0           = y0;
        seg_next.y1           = y1;
        seg_next.past_last    = ~hit;
        seg_next.direct       = ~hit | first[0] | (x1 == req.pixel_value);
        seg_next.direct_value = hit ? y1 : knot_out_reg[MAX_POINTS-1];
    end

    // Advance the stage; loads leave nothing behind
    assign seg_valid_next = pixel_take | (seg_valid_reg & ~seg_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    // An interpolated pixel lies strictly inside its segment
    a_seg_inside: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid_reg && !seg_reg.direct |->
            (seg_reg.x0 < seg_reg.px) && (seg_reg.px < seg_reg.x1))
        else $error("interpolated pixel outside its segment");

    // Saturation always takes the direct path
    a_sat_direct: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid_reg && seg_reg.past_last |-> seg_reg.direct)
        else $error("saturated pixel sent to interpolation");

endmodule

// ----- rtl/pltc_blend.sv -----
// Two-stage weighting: multiply each end level by the pixel's distance to the
// other end, then sum into the numerator. Imports pltc_pkg.
module pltc_blend
    import pltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       seg_valid,
    output logic       seg_ready,
    input  pltc_seg_t  seg,
    output logic       frac_valid,
    input  logic       frac_ready,
    output pltc_frac_t frac
);

    logic       prod_valid_reg;
    logic       prod_valid_next;
    pltc_prod_t prod_reg;
    pltc_prod_t prod_next;
    logic       frac_valid_reg;
    logic       frac_valid_next;
    pltc_frac_t frac_reg;
    pltc_frac_t frac_next;

    logic prod_ready;
    logic frac_stage_ready;
    logic prod_load;
    logic frac_load;

    assign frac_stage_ready = ~frac_valid_reg | frac_ready;
    assign prod_ready       = ~prod_valid_reg | frac_stage_ready;
    assign seg_ready        = prod_ready;
    assign prod_load        = seg_valid & prod_ready;
    assign frac_load        = prod_valid_reg & frac_stage_ready;

    // Form the two weighted terms and the span
    always_comb
    begin
        level_t d1;
        level_t d0;
        d1 = seg.x1 - seg.px;
        d0 = seg.px - seg.x0;
        prod_next.direct       = seg.direct;
        prod_next.direct_value = seg.direct_value;
        prod_next.past_last    = seg.past_last;
        prod_next.p0           = seg.y0 * d1;
        prod_next.p1           = seg.y1 * d0;
        prod_next.den          = seg.x1 - seg.x0;
    end

    // Sum the terms; the total never exceeds 255 times the span
    always_comb
    begin
        logic [PROD_W:0] sum;
        sum = {1'b0, prod_reg.p0} + {1'b0, prod_reg.p1};
        frac_next.direct       = prod_reg.direct;
        frac_next.direct_value = prod_reg.direct_value;
        frac_next.past_last    = prod_reg.past_last;
        frac_next.num          = sum[PROD_W-1:0];
        frac_next.den          = prod_reg.den;
    end

    assign prod_valid_next = prod_load | (prod_valid_reg & ~frac_stage_ready);
    assign frac_valid_next = frac_load | (frac_valid_reg & ~frac_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            frac_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            frac_valid_reg <= frac_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
        if (frac_load)
        begin
            frac_reg <= frac_next;
        end
    end

    assign frac_valid = frac_valid_reg;
    assign frac       = frac_reg;

    // Quotient must fit in one level: high numerator byte below the span
    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        frac_valid_reg && !frac_reg.direct |->
            frac_reg.num[PROD_W-1:LEVEL_W] < frac_reg.den)
        else $error("interpolation numerator out of range");

endmodule

// ----- rtl/pltc_div.sv -----
// Pipelined restoring divider: DIV_BITS quotient bits per stage over
// DIV_STAGES stages, last stage doubles as the result register. Imports pltc_pkg.
module pltc_div
    import pltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frac_valid,
    output logic       frac_ready,
    input  pltc_frac_t frac,
    output logic       res_valid,
    input  logic       res_stall,
    output pltc_res_t  res
);

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] valid_next;
    pltc_div_t             stage_reg  [DIV_STAGES];
    pltc_div_t             stage_next [DIV_STAGES];
    pltc_div_t             stage_in   [DIV_STAGES];
    pltc_div_t             seed;
    logic [DIV_STAGES-1:0] stage_in_valid;
    logic [DIV_STAGES:0]   rdy;
    logic [DIV_STAGES-1:0] load;

    assign rdy[DIV_STAGES] = ~res_stall;
    assign frac_ready      = rdy[0];

    // Seed the remainder with the high numerator byte
    always_comb
    begin
        seed.direct       = frac.direct;
        seed.direct_value = frac.direct_value;
        seed.past_last    = frac.past_last;
        seed.rem          = frac.num[PROD_W-1:LEVEL_W];
        seed.quo          = '0;
        seed.num_lo       = frac.num[LEVEL_W-1:0];
        seed.den          = frac.den;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        if (k > 0)
        begin : g_link
            assign stage_in[k]       = stage_reg[k-1];
            assign stage_in_valid[k] = valid_reg[k-1];
        end
        else
        begin : g_seed
            assign stage_in[k]       = seed;
            assign stage_in_valid[k] = frac_valid;
        end

        assign rdy[k]  = ~valid_reg[k] | rdy[k+1];
        assign load[k] = stage_in_valid[k] & rdy[k];

        // Shift in DIV_BITS numerator bits one at a time, subtract the divisor when it fits
        always_comb
        begin
            logic [LEVEL_W:0] trial;
            int               bit_idx;
            stage_next[k] = stage_in[k];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                bit_idx = LEVEL_W - 1 - (k * DIV_BITS + b);
                trial   = {stage_next[k].rem, stage_next[k].num_lo[bit_idx]};
                if (trial >= {1'b0, stage_next[k].den})
                begin
                    trial                       = trial - {1'b0, stage_next[k].den};
                    stage_next[k].quo[bit_idx] = 1'b1;
                end
                stage_next[k].rem = trial[LEVEL_W-1:0];
            end
        end

        assign valid_next[k] = load[k] | (valid_reg[k] & ~rdy[k+1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Pick the direct level or the quotient
    assign res_valid = valid_reg[DIV_STAGES-1];
    assign res.mapped_value = stage_reg[DIV_STAGES-1].direct ?
                              stage_reg[DIV_STAGES-1].direct_value :
                              stage_reg[DIV_STAGES-1].quo;
    assign res.past_last_point = stage_reg[DIV_STAGES-1].past_last;

    // Partial remainder stays below the divisor on the division path
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !stage_reg[0].direct |-> stage_reg[0].rem < stage_reg[0].den)
        else $error("divider remainder not reduced");

endmodule

// ----- rtl/piecewise_linear_tone_curve_unit.sv -----
// Top level of the piecewise-linear tone curve unit: breakpoint lookup,
// weighting and divider pipeline. Depends on pltc_pkg, pltc_lookup, pltc_blend, pltc_div.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  request  | req_valid, req_stall, req        | breakpoint load or pixel
//  result   | res_valid, res_stall, res        | mapped level and saturation flag
//
// A request is taken every cycle unless req_stall is high; a pixel result passes
// the lookup, multiply and sum registers, then 4 divider stages of 2 quotient bits.
// A load updates the table at its own edge and the pixel after it sees it.
// Reset sets every breakpoint to level 255 and empties the pipeline.
// Stall ripples back stage by stage; empty stages still fill under stall.
module piecewise_linear_tone_curve_unit
    import pltc_pkg::*;
#(
    parameter int MAX_POINTS = PLTC_MAX_POINTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  pltc_req_t req,
    output logic      res_valid,
    input  logic      res_stall,
    output pltc_res_t res
);

    logic       seg_valid;
    logic       seg_ready;
    pltc_seg_t  seg;
    logic       frac_valid;
    logic       frac_ready;
    pltc_frac_t frac;

    // Find the segment for each pixel
    pltc_lookup #(
        .MAX_POINTS (MAX_POINTS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    // Weight the end levels
    pltc_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .frac       (frac)
    );

    // Divide by the span and drive the result
    pltc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .frac       (frac),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
